// ===== hw/rtl/crs_pkg.sv =====
// Shared types, constants and FP32 datapath functions for the complex row scaler.
package crs_pkg;

    localparam int X_DEPTH_DEF = 1024;
    localparam int POS_W       = 10;
    localparam int ROWS_W      = 11;
    localparam int STRIDE_W    = 12;
    localparam int IDX_W       = ROWS_W + STRIDE_W;

    // Item kinds carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ELEM = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ROWS   = 1'b0;
    localparam logic CFG_STRIDE = 1'b1;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        K_NUM,
        K_ZERO,
        K_INF,
        K_NAN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               sgn;
        logic signed [9:0]  exp;
        logic [47:0]        prod;
    } t_mul_raw;

    typedef struct packed {
        t_kind              kind;
        logic               sgn;
        logic               zsgn;
        logic               sub;
        logic signed [9:0]  exp;
        logic [26:0]        ma;
        logic [26:0]        mb;
    } t_add_aln;

    typedef struct packed {
        t_kind              kind;
        logic               sgn;
        logic               zsgn;
        logic signed [9:0]  exp;
        logic [27:0]        sum;
    } t_add_sum;

    typedef struct packed {
        t_kind              kind;
        logic               sgn;
        logic               zsgn;
        logic signed [9:0]  exp;
        logic [27:0]        sum;
        logic [4:0]         lz;
    } t_add_nrm;

    // Round to nearest-even and pack; results below the normal range flush to zero,
    // except the one that rounds up to the smallest normal.
    function automatic logic [31:0] round_pack(logic s, logic signed [9:0] e,
                                               logic [23:0] m, logic g, logic st);
        logic        up;
        logic [22:0] mh;
        logic [30:0] r;
        round_pack = {s, 31'd0};
        if (e >= 10'sd255) begin
            round_pack = {s, 8'hFF, 23'd0};
        end else if (e == 10'sd0) begin
            mh = m[23:1];
            up = m[0] & (g | st | mh[0]);
            if (up && (&mh)) begin
                round_pack = {s, 8'd1, 23'd0};
            end
        end else if (e > 10'sd0) begin
            up = g & (st | m[0]);
            r  = {e[7:0], m[22:0]} + 31'(up);
            round_pack = {s, r};
        end
    endfunction

    function automatic t_mul_raw mul_a(logic [31:0] a, logic [31:0] b);
        t_mul_raw q;
        logic za, zb, ia, ib, na, nb;
        za = (a[30:23] == 8'd0);
        zb = (b[30:23] == 8'd0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (na || nb || (ia && zb) || (za && ib)) begin
            q.kind = K_NAN;
        end else if (ia || ib) begin
            q.kind = K_INF;
        end else if (za || zb) begin
            q.kind = K_ZERO;
        end else begin
            q.kind = K_NUM;
        end
        q.sgn  = a[31] ^ b[31];
        q.exp  = signed'({2'b00, a[30:23]}) + signed'({2'b00, b[30:23]}) - 10'sd127;
        q.prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        return q;
    endfunction

    function automatic logic [31:0] mul_b(t_mul_raw r);
        logic [31:0] q;
        case (r.kind)
            K_NAN:  q = QNAN;
            K_INF:  q = {r.sgn, 8'hFF, 23'd0};
            K_ZERO: q = {r.sgn, 31'd0};
            K_NUM: begin
                if (r.prod[47]) begin
                    q = round_pack(r.sgn, r.exp + 10'sd1, r.prod[47:24], r.prod[23],
                                   |r.prod[22:0]);
                end else begin
                    q = round_pack(r.sgn, r.exp, r.prod[46:23], r.prod[22],
                                   |r.prod[21:0]);
                end
            end
            default: q = QNAN;
        endcase
        return q;
    endfunction

    // Classify, order by magnitude and align the smaller operand with sticky.
    function automatic t_add_aln add_a(logic [31:0] a, logic [31:0] b, logic neg_b);
        t_add_aln    q;
        logic        sa, sb, ia, ib, na, nb, a_big;
        logic [26:0] sga, sgb, big, sml, mask;
        logic [7:0]  eb_, es_, d;
        sa  = a[31];
        sb  = b[31] ^ neg_b;
        ia  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        na  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        sga = (a[30:23] == 8'd0) ? 27'd0 : {1'b1, a[22:0], 3'b000};
        sgb = (b[30:23] == 8'd0) ? 27'd0 : {1'b1, b[22:0], 3'b000};
        a_big = (a[30:0] >= b[30:0]);
        big = a_big ? sga : sgb;
        sml = a_big ? sgb : sga;
        eb_ = a_big ? a[30:23] : b[30:23];
        es_ = a_big ? b[30:23] : a[30:23];
        d   = eb_ - es_;
        q.ma = big;
        if (d >= 8'd27) begin
            q.mb = {26'd0, |sml};
        end else begin
            mask = ~(27'h7FF_FFFF << d[4:0]);
            q.mb = (sml >> d[4:0]) | {26'd0, |(sml & mask)};
        end
        q.zsgn = sa & sb;
        q.sub  = sa ^ sb;
        q.exp  = signed'({2'b00, eb_});
        if (na || nb || (ia && ib && (sa != sb))) begin
            q.kind = K_NAN;
            q.sgn  = 1'b0;
        end else if (ia || ib) begin
            q.kind = K_INF;
            q.sgn  = ia ? sa : sb;
        end else begin
            q.kind = K_NUM;
            q.sgn  = a_big ? sa : sb;
        end
        return q;
    endfunction

    function automatic t_add_sum add_b(t_add_aln r);
        t_add_sum q;
        q.kind = r.kind;
        q.sgn  = r.sgn;
        q.zsgn = r.zsgn;
        q.exp  = r.exp;
        q.sum  = r.sub ? ({1'b0, r.ma} - {1'b0, r.mb}) : ({1'b0, r.ma} + {1'b0, r.mb});
        return q;
    endfunction

    function automatic t_add_nrm add_c(t_add_sum r);
        t_add_nrm q;
        q.kind = r.kind;
        q.sgn  = r.sgn;
        q.zsgn = r.zsgn;
        q.exp  = r.exp;
        q.sum  = r.sum;
        q.lz   = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (r.sum[i]) begin
                q.lz = 5'(26 - i);
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] add_d(t_add_nrm r);
        logic [31:0] q;
        logic [26:0] nrm;
        nrm = r.sum[26:0] << r.lz;
        case (r.kind)
            K_NAN:  q = QNAN;
            K_INF:  q = {r.sgn, 8'hFF, 23'd0};
            K_ZERO: q = {r.zsgn, 31'd0};
            K_NUM: begin
                if (r.sum == 28'd0) begin
                    q = {r.zsgn, 31'd0};
                end else if (r.sum[27]) begin
                    q = round_pack(r.sgn, r.exp + 10'sd1, r.sum[27:4], r.sum[3], |r.sum[2:0]);
                end else begin
                    q = round_pack(r.sgn, r.exp - signed'({5'd0, r.lz}), nrm[26:3], nrm[2],
                                   |nrm[1:0]);
                end
            end
            default: q = QNAN;
        endcase
        return q;
    endfunction

endpackage

// ===== hw/rtl/complex_row_scale.sv =====
// Complex row scaler: C = x[idx(row)] * A for FP32 complex data, one item per cycle.
// A load item (tuser 0) writes x[position] and gives no result; an element item
// (tuser 1) gives one result, in order. Both kinds can be accepted every cycle;
// the whole pipeline stalls only while a result waits at the output. Each element
// passes through the index multiply, the registered read of the x memory and the
// six FP stages of the complex multiplier. An element whose row or x index is out
// of range returns zero data with tuser set. Write the configuration only while no
// element is in flight.
module complex_row_scale #(
    parameter int X_DEPTH = crs_pkg::X_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [79:0]                s_axis_tdata,  // position[9:0], re_bits, im_bits, zero pad
    input  logic                       s_axis_tuser,  // opcode
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,  // c_real[31:0], c_imag[63:32]
    output logic                       m_axis_tuser,  // range_error
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [crs_pkg::STRIDE_W-1:0] i_cfg_data
);
    import crs_pkg::*;

    localparam int AW = $clog2(X_DEPTH);

    logic [ROWS_W-1:0]          r_rows;
    logic [STRIDE_W-1:0]        r_stride;

    logic                       w_adv, w_acc;
    logic [POS_W-1:0]           w_pos;
    logic [31:0]                w_re, w_im;
    logic                       w_neg;
    logic [STRIDE_W-1:0]        w_mag;
    logic                       w_oor;
    logic [63:0]                w_x;
    logic [31:0]                w_cre, w_cim;

    logic                       r_wv1;
    logic [AW-1:0]              r_waddr1;
    logic [63:0]                r_wdata1;

    logic                       r_v1, r_err1;
    logic [ROWS_W-1:0]          r_base1;
    logic [STRIDE_W-1:0]        r_mag1;
    logic [31:0]                r_ar1, r_ai1;
    logic                       r_v2, r_err2;
    logic [IDX_W-1:0]           r_idx2;
    logic [31:0]                r_ar2, r_ai2;
    logic                       r_v3, r_err3;
    logic [31:0]                r_ar3, r_ai3;
    logic [5:0]                 r_vp, r_ep;

    assign w_pos = s_axis_tdata[9:0];
    assign w_re  = s_axis_tdata[41:10];
    assign w_im  = s_axis_tdata[73:42];

    assign w_adv         = !r_vp[5] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;

    assign w_neg = r_stride[STRIDE_W-1];
    assign w_mag = w_neg ? (STRIDE_W'(0) - r_stride) : r_stride;
    assign w_oor = (32'(r_idx2) >= 32'(X_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= ROWS_W'(1);
            r_stride <= STRIDE_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ROWS) begin
                r_rows <= i_cfg_data[ROWS_W-1:0];
            end else begin
                r_stride <= i_cfg_data;
            end
        end
    end

    // Valid and error bits travel with the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv1 <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_vp  <= '0;
        end else if (w_adv) begin
            r_wv1 <= w_acc && (s_axis_tuser == OP_LOAD) && (32'(w_pos) < 32'(X_DEPTH));
            r_v1  <= w_acc && (s_axis_tuser == OP_ELEM);
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_vp  <= {r_vp[4:0], r_v3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // hold a load one stage so an element accepted just before it reads the old entry
            r_waddr1 <= AW'(w_pos);
            r_wdata1 <= {w_im, w_re};
            r_err1  <= (ROWS_W'(w_pos) >= r_rows);
            r_base1 <= w_neg ? (r_rows - ROWS_W'(1) - ROWS_W'(w_pos)) : ROWS_W'(w_pos);
            r_mag1  <= w_mag;
            r_ar1   <= w_re;
            r_ai1   <= w_im;
            r_err2  <= r_err1;
            r_idx2  <= IDX_W'(r_base1) * IDX_W'(r_mag1);
            r_ar2   <= r_ar1;
            r_ai2   <= r_ai1;
            r_err3  <= r_err2 || w_oor;
            r_ar3   <= r_ar2;
            r_ai3   <= r_ai2;
            r_ep    <= {r_ep[4:0], r_err3};
        end
    end

    crs_ram #(
        .WIDTH (64),
        .DEPTH (X_DEPTH)
    ) u_xmem (
        .i_clk   (i_clk),
        .i_we    (r_wv1 && w_adv),
        .i_waddr (r_waddr1),
        .i_wdata (r_wdata1),
        .i_re    (w_adv),
        .i_raddr (AW'(r_idx2)),
        .o_rdata (w_x)
    );

    crs_cmul u_cmul (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_ar  (r_ar3),
        .i_ai  (r_ai3),
        .i_xr  (w_x[31:0]),
        .i_xi  (w_x[63:32]),
        .o_re  (w_cre),
        .o_im  (w_cim)
    );

    assign m_axis_tvalid = r_vp[5];
    assign m_axis_tuser  = r_ep[5];
    assign m_axis_tdata  = r_ep[5] ? 64'd0 : {w_cim, w_cre};

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_vp) && $stable(r_v3) && $stable(r_v2) && $stable(r_v1)))
        else $error("pipeline moved during a stall");

    a_nan_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'd0))
        |-> (m_axis_tdata[31:0] == QNAN))
        else $error("non-canonical NaN on real part");

    a_nan_im: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[62:55] == 8'hFF) && (m_axis_tdata[54:32] != 23'd0))
        |-> (m_axis_tdata[63:32] == QNAN))
        else $error("non-canonical NaN on imaginary part");

    a_no_subn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tdata[30:23] == 8'd0) || (m_axis_tdata[62:55] == 8'd0)))
        |-> ((m_axis_tdata[30:23] != 8'd0 || m_axis_tdata[22:0] == 23'd0) &&
             (m_axis_tdata[62:55] != 8'd0 || m_axis_tdata[54:32] == 23'd0)))
        else $error("subnormal result not flushed");
`endif
endmodule

// ===== hw/rtl/crs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module crs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/crs_cmul.sv =====
// Six-stage FP32 complex multiplier: four products, then one subtract and one add.
module crs_cmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_ar,
    input  logic [31:0] i_ai,
    input  logic [31:0] i_xr,
    input  logic [31:0] i_xi,
    output logic [31:0] o_re,
    output logic [31:0] o_im
);
    import crs_pkg::*;

    t_mul_raw    r_mr [4];
    logic [31:0] r_p  [4];
    t_add_aln    r_aln [2];
    t_add_sum    r_sum [2];
    t_add_nrm    r_nrm [2];
    logic [31:0] r_re, r_im;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mr[0] <= mul_a(i_ar, i_xr);
            r_mr[1] <= mul_a(i_ai, i_xi);
            r_mr[2] <= mul_a(i_ar, i_xi);
            r_mr[3] <= mul_a(i_ai, i_xr);
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= mul_b(r_mr[k]);
            end
            // real = ar*xr - ai*xi, imag = ar*xi + ai*xr
            r_aln[0] <= add_a(r_p[0], r_p[1], 1'b1);
            r_aln[1] <= add_a(r_p[2], r_p[3], 1'b0);
            for (int k = 0; k < 2; k++) begin
                r_sum[k] <= add_b(r_aln[k]);
                r_nrm[k] <= add_c(r_sum[k]);
            end
            r_re <= add_d(r_nrm[0]);
            r_im <= add_d(r_nrm[1]);
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the complex row scaler with an FP32 predictor.
module tb_top;
    import crs_pkg::*;

    localparam int ITEMS     = 1500;
    localparam int PIPE_WAIT = 14;
    localparam int WD_LIMIT  = 4000;

    typedef struct {
        logic        op;
        logic [9:0]  pos;
        logic [31:0] re;
        logic [31:0] im;
        bit          typed;
        logic [31:0] t_re;
        logic [31:0] t_im;
        logic        t_err;
    } t_row;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        err;
    } t_scaled;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [11:0] i_cfg_data = '0;

    complex_row_scale u_top (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0] x_diag [1024];
    bit          x_valid [1024];
    logic [10:0] row_count;
    logic [11:0] stride_raw;

    t_scaled     pending_q[$];
    int          fail_count = 0;
    int          n_loads = 0, n_elems = 0, n_flagged = 0, n_cfg = 0;
    bit          quiet_src = 1'b0, quiet_snk = 1'b0;
    int          idle_cycles = 0;

    function automatic logic [31:0] fp_tidy(logic [31:0] u);
        if (u[30:23] == 8'd0) return {u[31], 31'd0};
        if (u[30:23] == 8'hFF && u[22:0] != 0) return QNAN;
        return u;
    endfunction

    // Round an exact value m * 2^e2 to FP32 nearest-even; flush below normal range.
    function automatic logic [31:0] fp_round(logic s, int e2, logic [63:0] m);
        int          p, be, sh;
        logic [63:0] r, lost;
        logic        g, st, up;
        p = 0;
        for (int i = 0; i < 64; i++) if (m[i]) p = i;
        be = p + e2 + 127;
        sh = p - 23;
        if (be < 1) sh += 1 - be;
        g = 1'b0;
        st = 1'b0;
        if (sh <= 0) begin
            r = m << (-sh);
        end else if (sh > 64) begin
            r = '0;
            st = 1'b1;
        end else begin
            r = (sh == 64) ? 64'd0 : (m >> sh);
            g = m[sh-1];
            lost = m & ((64'd1 << (sh - 1)) - 64'd1);
            st = |lost;
        end
        up = g & (st | r[0]);
        r = r + 64'(up);
        if (be < 1) return r[23] ? {s, 8'd1, 23'd0} : {s, 31'd0};
        if (r[24]) begin
            r = r >> 1;
            be++;
        end
        if (be >= 255) return {s, 8'hFF, 23'd0};
        return {s, be[7:0], r[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a0, logic [31:0] b0);
        logic [31:0] a, b;
        logic        s, za, zb, ia, ib;
        a = fp_tidy(a0);
        b = fp_tidy(b0);
        s = a[31] ^ b[31];
        if (a == QNAN || b == QNAN) return QNAN;
        za = (a[30:0] == 0);
        zb = (b[30:0] == 0);
        ia = (a[30:23] == 8'hFF);
        ib = (b[30:23] == 8'hFF);
        if ((ia && zb) || (ib && za)) return QNAN;
        if (ia || ib) return {s, 8'hFF, 23'd0};
        if (za || zb) return {s, 31'd0};
        return fp_round(s, int'(a[30:23]) + int'(b[30:23]) - 254 - 46,
                        64'({1'b1, a[22:0]}) * 64'({1'b1, b[22:0]}));
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a0, logic [31:0] b0);
        logic [31:0] a, b, big, sml;
        logic [63:0] bm, sm, full, lost, res;
        logic [23:0] bmant, smant;
        int          d;
        a = fp_tidy(a0);
        b = fp_tidy(b0);
        if (a == QNAN || b == QNAN) return QNAN;
        if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) return QNAN;
        if (a[30:23] == 8'hFF) return a;
        if (b[30:23] == 8'hFF) return b;
        big = (a[30:0] >= b[30:0]) ? a : b;
        sml = (a[30:0] >= b[30:0]) ? b : a;
        bmant = (big[30:23] == 0) ? 24'd0 : {1'b1, big[22:0]};
        smant = (sml[30:23] == 0) ? 24'd0 : {1'b1, sml[22:0]};
        if (bmant == 0) return {a[31] & b[31], 31'd0};
        bm = 64'(bmant) << 30;
        d = int'(big[30:23]) - int'(sml[30:23]);
        if (d >= 54) begin
            sm = 64'(smant != 0);
        end else begin
            full = 64'(smant) << 30;
            sm = full >> d;
            lost = full & ((64'd1 << d) - 64'd1);
            sm[0] = sm[0] | (|lost);
        end
        res = (a[31] == b[31]) ? bm + sm : bm - sm;
        if (res == 0) return {a[31] & b[31], 31'd0};
        return fp_round(big[31], int'(big[30:23]) - 127 - 23 - 30, res);
    endfunction

    // x index of a row, or -1 when the row or the index is out of range
    function automatic int diag_index(logic [9:0] row);
        logic [31:0] mag, idx;
        if ({1'b0, row} >= row_count) return -1;
        mag = stride_raw[11] ? 32'((13'h1000 - {1'b0, stride_raw}) & 13'hFFF)
                             : 32'(stride_raw);
        if (stride_raw[11] && mag == 0) mag = 32'h800;
        idx = stride_raw[11] ? (32'(row_count) - 32'd1 - 32'(row)) * mag : 32'(row) * mag;
        if (idx >= 32'd1024) return -1;
        return int'(idx);
    endfunction

    function automatic t_scaled scale_elem(logic [9:0] row, logic [31:0] ar, logic [31:0] ai);
        t_scaled     r;
        int          k;
        logic [31:0] xr, xi;
        r = '{32'd0, 32'd0, 1'b1};
        k = diag_index(row);
        if (k < 0) return r;
        xr = x_diag[k][31:0];
        xi = x_diag[k][63:32];
        r.re  = fp_add(fp_mul(ar, xr), fp_mul(ai, xi) ^ 32'h8000_0000);
        r.im  = fp_add(fp_mul(ar, xi), fp_mul(ai, xr));
        r.err = 1'b0;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $time);
        fail_count++;
    endtask

    // Offer one item, idling now and then, and record its expectation on acceptance.
    task automatic send_item(logic op, logic [9:0] pos, logic [31:0] re, logic [31:0] im,
                             bit typed = 0, t_scaled fixed = '{0, 0, 0});
        t_scaled r;
        while (!quiet_src && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, im, re, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_LOAD) begin
            x_diag[pos]  = {im, re};
            x_valid[pos] = 1'b1;
            n_loads++;
        end else begin
            r = typed ? fixed : scale_elem(pos, re, im);
            pending_q.push_back(r);
            n_elems++;
            if (r.err) n_flagged++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_ROWS) row_count = val[10:0];
        else stride_raw = val;
        n_cfg++;
    endtask

    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(7))
            4: v[30:23] = $urandom_range(1) ? 8'($urandom_range(2)) : 8'($urandom_range(253, 255));
            5: v[30:0] = '0;
            6, 7: v[30:23] = 8'($urandom_range(112, 142));
            default: ;
        endcase
        return v;
    endfunction

    // receive side
    always @(posedge i_clk) begin
        m_axis_tready <= quiet_snk || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        t_scaled want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $display("unexpected item %h/%b (t=%0t)", m_axis_tdata, m_axis_tuser, $time);
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata[31:0] !== want.re) report("c_real", m_axis_tdata[31:0], want.re);
                if (m_axis_tdata[63:32] !== want.im)
                    report("c_imag", m_axis_tdata[63:32], want.im);
                if (m_axis_tuser !== want.err) report("range_error", 32'(m_axis_tuser), 32'(want.err));
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    t_row dir_rows[] = '{
        '{OP_ELEM, 10'd1,    32'h3F80_0000, 32'h0, 1, 32'h0, 32'h0, 1'b1},
        '{OP_ELEM, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 32'h0, 1'b1},
        '{OP_LOAD, 10'd0,    32'h3F80_0000, 32'h0, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h4000_0000, 32'h4040_0000, 1, 32'h4000_0000, 32'h4040_0000, 1'b0},
        '{OP_LOAD, 10'd0,    32'h7F7F_FFFF, 32'h7F7F_FFFF, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h7F7F_FFFF, 32'h0000_0001, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'hFFFF_FFFF, 32'h0, 1, QNAN, QNAN, 1'b0},
        '{OP_LOAD, 10'd0,    32'h7F80_0000, 32'h0, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h0, 32'h3F80_0000, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h807F_FFFF, 32'h3F80_0000, 0, 0, 0, 0},
        '{OP_LOAD, 10'd0,    32'h0080_0000, 32'h0080_0000, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h3F00_0000, 32'h3F00_0001, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h3F80_0000, 32'h3F80_0000, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h3F7F_FFFF, 32'hBF80_0001, 0, 0, 0, 0},
        '{OP_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0},
        '{OP_LOAD, 10'd0,    32'h7F7F_FFFF, 32'hFF7F_FFFF, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h4000_0000, 32'h4000_0000, 0, 0, 0, 0},
        '{OP_LOAD, 10'd0,    32'h3F80_0001, 32'h3F7F_FFFF, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'h3F80_0001, 32'hBF7F_FFFF, 0, 0, 0, 0},
        '{OP_ELEM, 10'd0,    32'hFF80_0000, 32'h7F80_0000, 0, 0, 0, 0}
    };

    // rows_in_use, x_stride pairs swept by the random part
    logic [11:0] cfg_plan[][2] = '{
        '{12'd1024, 12'd1}, '{12'd1024, 12'd0}, '{12'd1024, 12'hFFF}, '{12'd2047, 12'd1},
        '{12'd0, 12'd5}, '{12'd16, 12'hFC0}, '{12'd1024, 12'hC00}, '{12'd1024, 12'd1024},
        '{12'd1, 12'h800}, '{12'd33, 12'd31}, '{12'd700, 12'hFFE}
    };

    initial begin
        logic [9:0]  row;
        logic [31:0] ar, ai;
        int          k, per_phase;
        for (int i = 0; i < 1024; i++) x_valid[i] = 1'b0;
        row_count  = 11'd1;
        stride_raw = 12'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].re, dir_rows[i].im,
                      dir_rows[i].typed, '{dir_rows[i].t_re, dir_rows[i].t_im, dir_rows[i].t_err});
        drain();

        per_phase = ITEMS / cfg_plan.size();
        foreach (cfg_plan[p]) begin
            write_reg(CFG_ROWS, cfg_plan[p][0]);
            write_reg(CFG_STRIDE, cfg_plan[p][1]);
            quiet_src = (p == 2);
            quiet_snk = (p == 3);
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(99) < 20) begin
                    send_item(OP_LOAD, 10'($urandom), rand_fp(), rand_fp());
                end else begin
                    if (row_count != 0 && $urandom_range(99) < 85)
                        row = 10'($urandom_range(int'(row_count) - 1));
                    else
                        row = 10'($urandom);
                    k = diag_index(row);
                    // fill the x entry before its first read
                    if (k >= 0 && !x_valid[k]) send_item(OP_LOAD, 10'(k), rand_fp(), rand_fp());
                    ar = rand_fp();
                    ai = ($urandom_range(9) == 0) ? ar : rand_fp();
                    send_item(OP_ELEM, row, ar, ai);
                end
                // in phase 5 only, hold off once mid-phase until the pipe is empty
                if (p == 5 && n == per_phase / 2) drain();
            end
            quiet_src = 1'b0;
            quiet_snk = 1'b0;
            drain();
        end

        $display("covered %0d loads, %0d elements (%0d range errors) over %0d register writes",
                 n_loads, n_elems, n_flagged, n_cfg);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("mismatches: %0d", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
